// ===== src/tsl_pkg.sv =====
`timescale 1ns / 1ps

package tsl_pkg;

	// Text store geometry
	localparam int TEXT_DEPTH = 4096;
	localparam int POS_W      = $clog2(TEXT_DEPTH);
	localparam int LEN_W      = $clog2(TEXT_DEPTH + 1);
	localparam int SPAN_W     = 12;

	// Item action codes
	localparam logic [1:0] ACT_TEXT    = 2'd0;
	localparam logic [1:0] ACT_TOKEN   = 2'd1;
	localparam logic [1:0] ACT_END     = 2'd2;
	localparam logic [1:0] ACT_RESTART = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] symbol;
	} item_t;

	typedef struct packed {
		logic              found;
		logic [SPAN_W-1:0] span_start;
		logic [SPAN_W-1:0] span_end;
		logic              text_exhausted;
	} result_t;

endpackage

// ===== src/token_span_locator_core.sv =====
`timescale 1ns / 1ps

// Token span locator.
// Input channel (item_valid / item_stall / item): one transaction per item.
//   Text bytes are appended to an on-chip byte store, token bytes are
//   compared in order against the text starting at the cursor, an
//   end-of-token item produces one result, restart clears text and cursor.
// Output channel (result_valid / result_stall / result): one transaction
//   per end-of-token item, carrying found, span start/end and exhausted.
// Flow: text, end-of-token and restart items are accepted without holding
//   the input. A token byte that needs a compare holds the next item for
//   the compare stage: the store read is registered and the compare
//   outcome sets the address of the next token byte. Token bytes that
//   cannot match (zero byte, past the text, exhausted) hold nothing.
// Result: presented the cycle after its end-of-token item is accepted.
// Reset: clears text length, cursor, token state and exhausted flag. The
//   store is not cleared; only written positions are ever read.
// Receiver stall: the result is held in the output register. Other items
//   keep flowing; only a further end-of-token item waits.
module token_span_locator_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  tsl_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output tsl_pkg::result_t  result
);

	localparam int POS_W  = tsl_pkg::POS_W;
	localparam int LEN_W  = tsl_pkg::LEN_W;
	localparam int SUM_W  = LEN_W + 1;

	// Text store
	logic [7:0] text_mem [tsl_pkg::TEXT_DEPTH];
	logic [7:0] rd_data_s1;

	// Architectural state
	logic [LEN_W-1:0] text_len_q;
	logic [LEN_W-1:0] cursor_q;
	logic [LEN_W-1:0] match_cnt_q;
	logic [POS_W-1:0] first_q;
	logic [POS_W-1:0] last_q;
	logic             any_q;
	logic             exhausted_q;

	// Compare stage
	logic             cmp_valid_s1;
	logic [7:0]       sym_s1;
	logic [POS_W-1:0] pos_s1;

	// Output register
	logic              out_valid_q;
	tsl_pkg::result_t  out_q;

	logic             accept;
	logic             is_text;
	logic             is_token;
	logic             is_end;
	logic             is_restart;
	logic [SUM_W-1:0] pos_sum;
	logic             cmp_issue;
	logic             cmp_hit;
	logic             end_hit;
	logic [LEN_W-1:0] next_cursor;
	logic             out_busy;

	// Decode
	assign is_text    = (item.action == tsl_pkg::ACT_TEXT);
	assign is_token   = (item.action == tsl_pkg::ACT_TOKEN);
	assign is_end     = (item.action == tsl_pkg::ACT_END);
	assign is_restart = (item.action == tsl_pkg::ACT_RESTART);

	// Interlock: compare in flight, or result slot held by the receiver
	assign out_busy   = out_valid_q && result_stall;
	assign item_stall = cmp_valid_s1 || (is_end && out_busy);
	assign accept     = item_valid && !item_stall;

	// Compare address and whether a compare can hit at all
	assign pos_sum   = SUM_W'(cursor_q) + SUM_W'(match_cnt_q);
	assign cmp_issue = accept && is_token && !exhausted_q && (item.symbol != 8'd0)
		&& (pos_sum < SUM_W'(text_len_q));
	assign cmp_hit   = cmp_valid_s1 && (rd_data_s1 == sym_s1);

	// End-of-token outcome
	assign end_hit     = any_q && !exhausted_q;
	assign next_cursor = LEN_W'(last_q) + LEN_W'(1);

	// Store write port
	always_ff @(posedge clk) begin
		if (accept && is_text && (text_len_q < LEN_W'(tsl_pkg::TEXT_DEPTH))) begin
			text_mem[text_len_q[POS_W-1:0]] <= item.symbol;
		end
	end

	// Store read port, registered
	always_ff @(posedge clk) begin
		if (cmp_issue) begin
			rd_data_s1 <= text_mem[pos_sum[POS_W-1:0]];
		end
	end

	// Compare stage payload
	always_ff @(posedge clk) begin
		if (cmp_issue) begin
			sym_s1 <= item.symbol;
			pos_s1 <= pos_sum[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_valid_s1 <= 1'b0;
		end else begin
			cmp_valid_s1 <= cmp_issue;
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_len_q  <= '0;
			cursor_q    <= '0;
			match_cnt_q <= '0;
			first_q     <= '0;
			last_q      <= '0;
			any_q       <= 1'b0;
			exhausted_q <= 1'b0;
		end else if (cmp_hit) begin
			if (!any_q) begin
				first_q <= pos_s1;
			end
			last_q      <= pos_s1;
			any_q       <= 1'b1;
			match_cnt_q <= match_cnt_q + LEN_W'(1);
		end else if (accept) begin
			if (is_text && (text_len_q < LEN_W'(tsl_pkg::TEXT_DEPTH))) begin
				text_len_q <= text_len_q + LEN_W'(1);
			end
			if (is_end) begin
				if (end_hit) begin
					cursor_q <= next_cursor;
					if (next_cursor >= text_len_q) begin
						exhausted_q <= 1'b1;
					end
				end
				match_cnt_q <= '0;
				first_q     <= '0;
				last_q      <= '0;
				any_q       <= 1'b0;
			end
			if (is_restart) begin
				text_len_q  <= '0;
				cursor_q    <= '0;
				exhausted_q <= 1'b0;
				match_cnt_q <= '0;
				first_q     <= '0;
				last_q      <= '0;
				any_q       <= 1'b0;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && is_end) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_end) begin
			out_q.found          <= end_hit;
			out_q.span_start     <= end_hit ? tsl_pkg::SPAN_W'(first_q) : '0;
			out_q.span_end       <= end_hit ? tsl_pkg::SPAN_W'(last_q) : '0;
			out_q.text_exhausted <= exhausted_q || (end_hit && (next_cursor >= text_len_q));
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== src/tsl_checker.sv =====
`timescale 1ns / 1ps

module tsl_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input tsl_pkg::item_t    item,
	input logic              result_valid,
	input logic              result_stall,
	input tsl_pkg::result_t  result
);

	// A held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// A not-found result carries zero positions
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |-> (result.span_start == '0) && (result.span_end == '0))
		else $error("not-found result with nonzero span");

	// A found span is ordered
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.found |-> result.span_start <= result.span_end)
		else $error("span start after span end");

	// A new result follows an accepted end-of-token transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall
			&& (item.action == tsl_pkg::ACT_END)))
		else $error("result without end of token");

endmodule

bind token_span_locator_core tsl_checker u_tsl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ===== test/token_span_locator_core_tb.sv =====
`timescale 1ns / 1ps

module token_span_locator_core_tb;

	localparam int CYCLE_LIMIT = 1_000_000;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	tsl_pkg::item_t    item;
	logic              result_valid;
	logic              result_stall;
	tsl_pkg::result_t  result;

	token_span_locator_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Local copy of the locator state
	logic [7:0]  text_copy [tsl_pkg::TEXT_DEPTH];
	int unsigned text_len   = 0;
	int unsigned cursor_pos = 0;
	int unsigned hit_count  = 0;
	int unsigned span_first = 0;
	int unsigned span_last  = 0;
	bit          span_open  = 1'b0;
	bit          text_done  = 1'b0;

	tsl_pkg::result_t pending_spans [$];
	int unsigned err_count   = 0;
	int unsigned items_sent  = 0;
	int unsigned cycle_count = 0;
	bit          send_burst  = 1'b0;
	bit          recv_burst  = 1'b0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Wait draw per transaction; burst mode gives stretches without gaps
	function automatic int unsigned draw_wait(input bit burst);
		if (burst)
			return 0;
		return $urandom_range(0, 11);
	endfunction

	// Mostly a small alphabet so tokens hit often; zero and full-range bytes now and then
	function automatic logic [7:0] rand_symbol();
		case ($urandom_range(0, 15))
			0:       return 8'h00;
			1:       return 8'($urandom);
			default: return 8'h41 + 8'($urandom_range(0, 3));
		endcase
	endfunction

	// Update the local state for one accepted transaction and queue any span result
	task automatic locate_step(input tsl_pkg::item_t it);
		tsl_pkg::result_t span;
		int unsigned      pos;
		case (it.action)
			tsl_pkg::ACT_TEXT: begin
				if (text_len < tsl_pkg::TEXT_DEPTH) begin
					text_copy[text_len] = it.symbol;
					text_len++;
				end
			end
			tsl_pkg::ACT_TOKEN: begin
				if (!text_done && it.symbol != 8'h00) begin
					pos = cursor_pos + hit_count;
					if (pos < text_len && pos < tsl_pkg::TEXT_DEPTH &&
							text_copy[pos] == it.symbol) begin
						if (!span_open)
							span_first = pos;
						span_last = pos;
						span_open = 1'b1;
						hit_count++;
					end
				end
			end
			tsl_pkg::ACT_END: begin
				span = '0;
				if (span_open && !text_done) begin
					span.found      = 1'b1;
					span.span_start = span_first[tsl_pkg::SPAN_W-1:0];
					span.span_end   = span_last[tsl_pkg::SPAN_W-1:0];
					cursor_pos      = span_last + 1;
					if (cursor_pos >= text_len)
						text_done = 1'b1;
				end
				span.text_exhausted = text_done;
				pending_spans.push_back(span);
				hit_count  = 0;
				span_first = 0;
				span_last  = 0;
				span_open  = 1'b0;
			end
			tsl_pkg::ACT_RESTART: begin
				text_len   = 0;
				cursor_pos = 0;
				text_done  = 1'b0;
				hit_count  = 0;
				span_first = 0;
				span_last  = 0;
				span_open  = 1'b0;
			end
			default: begin
			end
		endcase
	endtask

	// Drive one transaction after a random gap and hold it until accepted
	task automatic send_item(input logic [1:0] act, input logic [7:0] sym);
		tsl_pkg::item_t it;
		int unsigned    gap;
		it  = '{action: act, symbol: sym};
		gap = draw_wait(send_burst);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall !== 1'b0);
		locate_step(it);
		items_sent++;
	endtask

	task automatic send_bytes(input logic [1:0] act, input string s);
		foreach (s[i])
			send_item(act, s[i]);
	endtask

	// Consecutive tokens in a short text, then exhaustion
	task automatic test_basic_spans();
		send_item(tsl_pkg::ACT_RESTART, 8'hFF);
		send_bytes(tsl_pkg::ACT_TEXT, "abc");
		send_bytes(tsl_pkg::ACT_TOKEN, "ab");
		send_item(tsl_pkg::ACT_END, 8'h00);
		// 'x' misses position 2, 'c' then hits it and reaches the end of text
		send_bytes(tsl_pkg::ACT_TOKEN, "xc");
		send_item(tsl_pkg::ACT_END, 8'hFF);
		// token bytes after exhaustion are ignored
		send_item(tsl_pkg::ACT_TOKEN, "a");
		send_item(tsl_pkg::ACT_END, 8'h5A);
	endtask

	// Zero bytes in text and token never match; extreme symbol values
	task automatic test_zero_bytes();
		send_item(tsl_pkg::ACT_RESTART, 8'h00);
		send_item(tsl_pkg::ACT_TEXT, 8'hFF);
		send_item(tsl_pkg::ACT_TEXT, 8'h00);
		send_item(tsl_pkg::ACT_TEXT, 8'h7F);
		send_item(tsl_pkg::ACT_TOKEN, 8'h00);
		send_item(tsl_pkg::ACT_TOKEN, 8'hFF);
		send_item(tsl_pkg::ACT_TOKEN, 8'h00);
		send_item(tsl_pkg::ACT_TOKEN, 8'h7F);
		send_item(tsl_pkg::ACT_END, 8'h80);
	endtask

	// Empty text, text appended after a token, compare past the text, restart
	task automatic test_text_edges();
		send_item(tsl_pkg::ACT_RESTART, 8'hAA);
		send_item(tsl_pkg::ACT_TOKEN, "m");
		send_item(tsl_pkg::ACT_END, 8'h00);
		send_item(tsl_pkg::ACT_TEXT, "m");
		send_bytes(tsl_pkg::ACT_TOKEN, "mm");
		send_item(tsl_pkg::ACT_END, 8'h01);
		// restart must clear the exhausted flag
		send_item(tsl_pkg::ACT_RESTART, 8'h00);
		send_item(tsl_pkg::ACT_END, 8'hFE);
	endtask

	// Text followed by tokens taken from the text at the cursor, with
	// corrupted bytes, late text and some raw noise
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned n_len;
		int unsigned idx;
		logic [7:0]  b;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			send_burst = ($urandom_range(0, 3) == 0);
			recv_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 6))
					send_item(2'($urandom_range(0, 3)), 8'($urandom));
			end else begin
				if (text_len == 0 || (text_done && $urandom_range(0, 3) != 0) ||
						$urandom_range(0, 5) == 0)
					send_item(tsl_pkg::ACT_RESTART, 8'($urandom));
				repeat ($urandom_range(1, 24))
					send_item(tsl_pkg::ACT_TEXT, rand_symbol());
				repeat ($urandom_range(1, 5)) begin
					if ($urandom_range(0, 5) == 0)
						repeat ($urandom_range(1, 3))
							send_item(tsl_pkg::ACT_TEXT, rand_symbol());
					n_len = $urandom_range(0, 6);
					for (int k = 0; k < n_len; k++) begin
						idx = cursor_pos + k;
						b = (idx < text_len) ? text_copy[idx] : rand_symbol();
						if ($urandom_range(0, 7) == 0)
							b = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
						send_item(tsl_pkg::ACT_TOKEN, b);
					end
					send_item(tsl_pkg::ACT_END, 8'($urandom));
				end
			end
		end
	endtask

	// Result side: random stall, then compare each accepted transaction
	initial begin : span_checker
		tsl_pkg::result_t want;
		int unsigned      n;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = draw_wait(recv_burst);
			@(negedge clk);
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (result_valid !== 1'b1);
			if (pending_spans.size() == 0) begin
				$error("result with nothing pending: %p", result);
				err_count++;
			end else begin
				want = pending_spans.pop_front();
				if (result.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, result.found);
					err_count++;
				end
				if (result.span_start !== want.span_start) begin
					$error("span_start: expected %0d, got %0d", want.span_start,
						result.span_start);
					err_count++;
				end
				if (result.span_end !== want.span_end) begin
					$error("span_end: expected %0d, got %0d", want.span_end, result.span_end);
					err_count++;
				end
				if (result.text_exhausted !== want.text_exhausted) begin
					$error("text_exhausted: expected %0d, got %0d", want.text_exhausted,
						result.text_exhausted);
					err_count++;
				end
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : main_seq
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_basic_spans();
		test_zero_bytes();
		test_text_edges();
		test_random_traffic(720);

		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_spans.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== token_span_locator_core.f =====
src/tsl_pkg.sv
src/token_span_locator_core.sv
src/tsl_checker.sv
test/token_span_locator_core_tb.sv
